>>> src/object_bounding_radius_defines.svh
// assertion macros used by the object bounding radius rtl
// expects clk_i and rst_ni in the scope of use
`ifndef OBJECT_BOUNDING_RADIUS_DEFINES_SVH
`define OBJECT_BOUNDING_RADIUS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define OBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/obr_pkg.sv
// shape codes and shape group decode for the object bounding radius block
// no dependencies
`default_nettype none

package obr_pkg;

  localparam int unsigned ShapeW = 5;

  localparam logic [ShapeW-1:0] SHAPE_CYL_FIRST    = 5'd1;
  localparam logic [ShapeW-1:0] SHAPE_CYL_LAST     = 5'd4;
  localparam logic [ShapeW-1:0] SHAPE_PANEL_FIRST  = 5'd5;
  localparam logic [ShapeW-1:0] SHAPE_PANEL_LAST   = 5'd13;
  localparam logic [ShapeW-1:0] SHAPE_BOX          = 5'd14;
  localparam logic [ShapeW-1:0] SHAPE_SPHERE       = 5'd15;
  localparam logic [ShapeW-1:0] SHAPE_CONE         = 5'd16;
  localparam logic [ShapeW-1:0] SHAPE_SPHCYL_FIRST = 5'd17;
  localparam logic [ShapeW-1:0] SHAPE_SPHCYL_LAST  = 5'd18;
  localparam logic [ShapeW-1:0] SHAPE_SAIL_FIRST   = 5'd19;
  localparam logic [ShapeW-1:0] SHAPE_SAIL_LAST    = 5'd26;
  localparam logic [ShapeW-1:0] SHAPE_ANT_FIRST    = 5'd27;
  localparam logic [ShapeW-1:0] SHAPE_ANT_LAST     = 5'd29;

  typedef enum logic [2:0] {
    GRP_NONE,
    GRP_CYL,     // diameter, height
    GRP_PANEL,   // span, height
    GRP_BOX,     // max(width, depth), height
    GRP_SPHERE,  // largest dimension
    GRP_CONE,    // diameter, height, else box pair
    GRP_SPHCYL,  // diameter, height, else diameter, span
    GRP_ANT      // max(width, depth), span
  } grp_e;

  function automatic grp_e shape_group(logic [ShapeW-1:0] shape);
    grp_e grp;
    case (shape) inside
      [SHAPE_CYL_FIRST:SHAPE_CYL_LAST]:       grp = GRP_CYL;
      [SHAPE_PANEL_FIRST:SHAPE_PANEL_LAST]:   grp = GRP_PANEL;
      [SHAPE_SAIL_FIRST:SHAPE_SAIL_LAST]:     grp = GRP_PANEL;
      SHAPE_BOX:                              grp = GRP_BOX;
      SHAPE_SPHERE:                           grp = GRP_SPHERE;
      SHAPE_CONE:                             grp = GRP_CONE;
      [SHAPE_SPHCYL_FIRST:SHAPE_SPHCYL_LAST]: grp = GRP_SPHCYL;
      [SHAPE_ANT_FIRST:SHAPE_ANT_LAST]:       grp = GRP_ANT;
      default:                                grp = GRP_NONE;
    endcase
    return grp;
  endfunction

endpackage

`default_nettype wire

>>> src/object_bounding_radius.sv
// Hard-body radius of one object: picks two lengths a, b by shape group and returns
// floor(isqrt(a*a + b*b) / 2), or the largest length for a sphere, or one metre with
// used_default_o set when the shape is unknown, needed lengths are missing or all of a
// sphere's lengths are zero or absent. Lengths and the result are unsigned fixed point
// with FRAC_BITS fraction bits. One request is taken per cycle while in_stall_o is low.
// A request passes the select, square, square root and output stages in order; the
// square root resolves one result bit per pipeline stage. A stall on the output only
// holds the stages that are full, so empty stages keep taking requests.
// depends on obr_pkg and object_bounding_radius_defines.svh
`default_nettype none
`include "object_bounding_radius_defines.svh"

module object_bounding_radius
  import obr_pkg::*;
#(
  parameter int unsigned DIM_WIDTH = 20,
  parameter int unsigned FRAC_BITS = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [ShapeW-1:0]    shape_class_i,
  input  wire logic [DIM_WIDTH-1:0] diameter_len_i,
  input  wire logic [DIM_WIDTH-1:0] span_len_i,
  input  wire logic [DIM_WIDTH-1:0] height_len_i,
  input  wire logic [DIM_WIDTH-1:0] width_len_i,
  input  wire logic [DIM_WIDTH-1:0] depth_len_i,
  input  wire logic                 has_diameter_i,
  input  wire logic                 has_span_i,
  input  wire logic                 has_height_i,
  input  wire logic                 has_width_i,
  input  wire logic                 has_depth_i,

  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [DIM_WIDTH-1:0] radius_len_o,
  output      logic                 used_default_o
);

  localparam int unsigned DW = DIM_WIDTH;
  localparam int unsigned SW = 2 * DIM_WIDTH;       // width of a square
  localparam int unsigned QW = 2 * DIM_WIDTH - 1;   // width of (a*a + b*b) / 4
  localparam logic [DW-1:0] OneMetre =
    (FRAC_BITS < DIM_WIDTH) ? (DW'(1) << FRAC_BITS) : {DW{1'b1}};

  // ---------------------------------------------------------------- stage enables
  logic            en_s1, en_s2, en_out;
  logic [DW:0]     en_sq;

  logic            s1_vld_q, s2_vld_q, out_vld_q;
  logic [DW:0]     sq_vld_q;

  always_comb begin
    en_out = !out_vld_q || !out_stall_i;
    for (int k = DW; k >= 0; k--) begin
      if (k == DW) begin
        en_sq[k] = !sq_vld_q[k] || en_out;
      end else begin
        en_sq[k] = !sq_vld_q[k] || en_sq[k+1];
      end
    end
    en_s2 = !s2_vld_q || en_sq[0];
    en_s1 = !s1_vld_q || en_s2;
  end

  assign in_stall_o = !en_s1;

  // ---------------------------------------------------------------- stage 1: select
  grp_e          grp;
  logic [DW-1:0] wd_max, sph_max, sph_dw, sph_hx;
  logic [DW-1:0] sel_a, sel_b, sel_byp;
  logic          sel_ok, sel_sphere;

  always_comb begin
    grp     = shape_group(shape_class_i);
    wd_max  = (width_len_i > depth_len_i) ? width_len_i : depth_len_i;
    // absent lengths count as zero for the sphere
    sph_dw  = has_diameter_i ? diameter_len_i : '0;
    sph_hx  = has_height_i ? height_len_i : '0;
    if (has_width_i && (!has_depth_i || width_len_i > depth_len_i)) begin
      sph_max = width_len_i;
    end else begin
      sph_max = has_depth_i ? depth_len_i : '0;
    end
    if (sph_dw > sph_max) sph_max = sph_dw;
    if (sph_hx > sph_max) sph_max = sph_hx;

    sel_a      = diameter_len_i;
    sel_b      = height_len_i;
    sel_ok     = 1'b0;
    sel_sphere = 1'b0;
    case (grp)
      GRP_CYL: begin
        sel_ok = has_diameter_i && has_height_i;
      end
      GRP_PANEL: begin
        sel_a  = span_len_i;
        sel_ok = has_span_i && has_height_i;
      end
      GRP_BOX: begin
        sel_a  = wd_max;
        sel_ok = has_depth_i && has_width_i && has_height_i;
      end
      GRP_SPHERE: begin
        sel_sphere = 1'b1;
        sel_ok     = (sph_max != '0);
      end
      GRP_CONE: begin
        if (has_diameter_i && has_height_i) begin
          sel_ok = 1'b1;
        end else begin
          sel_a  = wd_max;
          sel_ok = has_depth_i && has_width_i && has_height_i;
        end
      end
      GRP_SPHCYL: begin
        if (has_diameter_i && has_height_i) begin
          sel_ok = 1'b1;
        end else begin
          sel_b  = span_len_i;
          sel_ok = has_diameter_i && has_span_i;
        end
      end
      GRP_ANT: begin
        sel_a  = wd_max;
        sel_b  = span_len_i;
        sel_ok = has_depth_i && has_width_i && has_span_i;
      end
      default: begin
        sel_ok = 1'b0;
      end
    endcase
    sel_byp = sel_ok ? sph_max : OneMetre;
  end

  logic [DW-1:0] s1_a_q, s1_b_q, s1_byp_q;
  logic          s1_use_q, s1_dflt_q;

  // ---------------------------------------------------------------- stage 2: square
  logic [2*DW-1:0] s2_a2_q, s2_b2_q;
  logic [DW-1:0]   s2_byp_q;
  logic            s2_use_q, s2_dflt_q;

  // ---------------------------------------------------------------- sqrt stages
  logic [2*DW:0]   sq_sum;
  logic [QW-1:0]   sq_rem_q  [DW+1];
  logic [DW-1:0]   sq_root_q [DW+1];
  logic [DW-1:0]   sq_byp_q  [DW+1];
  logic            sq_use_q  [DW+1];
  logic            sq_dflt_q [DW+1];

  logic [QW-1:0]   sq_rem_d  [DW];
  logic [DW-1:0]   sq_root_d [DW];

  assign sq_sum = {1'b0, s2_a2_q} + {1'b0, s2_b2_q};

  for (genvar k = 0; k < DW; k++) begin : g_sqrt
    localparam int unsigned Bit = DW - 1 - k;
    logic [QW-1:0] trial;
    logic          take;
    // root only holds bits above Bit, so the two terms never overlap
    assign trial = (QW'(sq_root_q[k]) << (Bit + 1)) | (QW'(1) << (2 * Bit));
    assign take  = (sq_rem_q[k] >= trial);
    assign sq_rem_d[k]  = take ? (sq_rem_q[k] - trial) : sq_rem_q[k];
    assign sq_root_d[k] = take ? (sq_root_q[k] | (DW'(1) << Bit)) : sq_root_q[k];
  end

  // ---------------------------------------------------------------- output stage
  logic [DW-1:0] out_radius_q;
  logic          out_dflt_q;

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en_s1) s1_vld_q <= in_valid_i;
      if (en_s2) s2_vld_q <= s1_vld_q;
      if (en_sq[0]) sq_vld_q[0] <= s2_vld_q;
      for (int k = 0; k < DW; k++) begin
        if (en_sq[k+1]) sq_vld_q[k+1] <= sq_vld_q[k];
      end
      if (en_out) out_vld_q <= sq_vld_q[DW];
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (en_s1 && in_valid_i) begin
      s1_a_q    <= sel_a;
      s1_b_q    <= sel_b;
      s1_byp_q  <= sel_byp;
      s1_use_q  <= sel_ok && !sel_sphere;
      s1_dflt_q <= !sel_ok;
    end
    if (en_s2 && s1_vld_q) begin
      s2_a2_q   <= SW'(s1_a_q) * SW'(s1_a_q);
      s2_b2_q   <= SW'(s1_b_q) * SW'(s1_b_q);
      s2_byp_q  <= s1_byp_q;
      s2_use_q  <= s1_use_q;
      s2_dflt_q <= s1_dflt_q;
    end
    if (en_sq[0] && s2_vld_q) begin
      sq_rem_q[0]  <= sq_sum[2*DW:2];
      sq_root_q[0] <= '0;
      sq_byp_q[0]  <= s2_byp_q;
      sq_use_q[0]  <= s2_use_q;
      sq_dflt_q[0] <= s2_dflt_q;
    end
    for (int k = 0; k < DW; k++) begin
      if (en_sq[k+1] && sq_vld_q[k]) begin
        sq_rem_q[k+1]  <= sq_rem_d[k];
        sq_root_q[k+1] <= sq_root_d[k];
        sq_byp_q[k+1]  <= sq_byp_q[k];
        sq_use_q[k+1]  <= sq_use_q[k];
        sq_dflt_q[k+1] <= sq_dflt_q[k];
      end
    end
    if (en_out && sq_vld_q[DW]) begin
      out_radius_q <= sq_use_q[DW] ? sq_root_q[DW] : sq_byp_q[DW];
      out_dflt_q   <= sq_dflt_q[DW];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign radius_len_o   = out_radius_q;
  assign used_default_o = out_dflt_q;

  // ---------------------------------------------------------------- assertions
  `OBR_ASSERT_NOW(a_default_is_one_metre, out_valid_o && used_default_o,
    radius_len_o == OneMetre, "default result is not one metre")
  `OBR_ASSERT_NOW(a_stall_only_when_full, in_stall_o,
    out_valid_o && out_stall_i && (&sq_vld_q) && s1_vld_q && s2_vld_q,
    "input stalled while the pipeline has a free stage")
  `OBR_ASSERT_NOW(a_sqrt_remainder_bound, sq_vld_q[DW] && sq_use_q[DW],
    sq_rem_q[DW] <= QW'({sq_root_q[DW], 1'b0}), "square root remainder out of range")
  `OBR_ASSERT_NOW(a_sphere_nonzero, s1_vld_q && !s1_use_q && !s1_dflt_q,
    s1_byp_q != '0, "sphere result of zero without default")
  `OBR_ASSERT_NEXT(a_output_fed_by_last_stage,
    en_out && sq_vld_q[DW] && !sq_use_q[DW],
    out_valid_o && (radius_len_o == $past(sq_byp_q[DW])),
    "bypass value lost on the way to the output")

endmodule

`default_nettype wire

>>> tb/tb_object_bounding_radius.sv
// testbench for object_bounding_radius: directed table, then random requests under
// several idle/stall mixes, each result checked in order against a table value or a local predictor
// depends on obr_pkg and the object_bounding_radius rtl
`timescale 1ns / 1ps

module tb_object_bounding_radius;
  import obr_pkg::*;

  localparam int unsigned DIM_W = 20;
  localparam int unsigned FRAC_W = 10;
  localparam int unsigned PIPE_DEPTH = DIM_W + 4;
  localparam int unsigned DRAIN_CYCLES = 2 * PIPE_DEPTH;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned NUM_DIRECTED = 25;

  localparam logic [DIM_W-1:0] DIM_MAX = {DIM_W{1'b1}};
  localparam logic [DIM_W-1:0] ONE_METRE = DIM_W'(1) << FRAC_W;

  // codes outside every shape group
  localparam logic [ShapeW-1:0] SHAPE_UNKNOWN = 5'd0;
  localparam logic [ShapeW-1:0] SHAPE_SPARE_LO = SHAPE_ANT_LAST + 5'd1;
  localparam logic [ShapeW-1:0] SHAPE_SPARE_HI = SHAPE_ANT_LAST + 5'd2;

  // presence flag order: diameter, span, height, width, depth
  localparam int unsigned HAS_DIA = 4;
  localparam int unsigned HAS_SPN = 3;
  localparam int unsigned HAS_HGT = 2;
  localparam int unsigned HAS_WID = 1;
  localparam int unsigned HAS_DEP = 0;

  typedef struct packed {
    logic [ShapeW-1:0] shape;
    logic [DIM_W-1:0]  dia;
    logic [DIM_W-1:0]  spn;
    logic [DIM_W-1:0]  hgt;
    logic [DIM_W-1:0]  wid;
    logic [DIM_W-1:0]  dep;
    logic [4:0]        has;
  } radius_req_t;

  typedef struct packed {
    logic [DIM_W-1:0] radius;
    logic             used_default;
  } radius_res_t;

  typedef struct packed {
    radius_req_t req;
    logic        known;
    radius_res_t res;
  } dir_row_t;

  localparam radius_res_t NO_RES = '{20'd0, 1'b0};
  localparam radius_res_t DEF_RES = '{ONE_METRE, 1'b1};

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{SHAPE_UNKNOWN, 20'd1000, 20'd1000, 20'd1000, 20'd1000, 20'd1000, 5'b11111},
      1'b1, DEF_RES},
    '{'{SHAPE_SPARE_LO, 20'd1000, 20'd1000, 20'd1000, 20'd1000, 20'd1000, 5'b11111},
      1'b1, DEF_RES},
    '{'{SHAPE_SPARE_HI, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 5'b11111},
      1'b1, DEF_RES},
    // present zero lengths are used as zero
    '{'{SHAPE_CYL_FIRST, 20'd0, 20'd9, 20'd0, 20'd9, 20'd9, 5'b10100},
      1'b1, '{20'd0, 1'b0}},
    '{'{SHAPE_CYL_LAST, 20'd3, 20'd0, 20'd4, 20'd0, 20'd0, 5'b10100},
      1'b1, '{20'd2, 1'b0}},
    '{'{SHAPE_CYL_LAST, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 5'b11111},
      1'b0, NO_RES},
    '{'{SHAPE_CYL_FIRST, 20'd5000, 20'd5000, 20'd5000, 20'd5000, 20'd5000, 5'b10000},
      1'b1, DEF_RES},
    '{'{SHAPE_PANEL_FIRST, 20'd0, 20'd12345, 20'd678, 20'd0, 20'd0, 5'b01100},
      1'b0, NO_RES},
    '{'{SHAPE_PANEL_LAST, 20'd0, 20'd12345, 20'd678, 20'd0, 20'd0, 5'b00100},
      1'b1, DEF_RES},
    '{'{SHAPE_BOX, 20'd0, 20'd0, 20'd400, 20'd100, 20'd900, 5'b00111},
      1'b0, NO_RES},
    '{'{SHAPE_BOX, 20'd0, 20'd0, 20'd400, 20'd100, 20'd900, 5'b00110},
      1'b1, DEF_RES},
    // sphere with every length zero
    '{'{SHAPE_SPHERE, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 5'b11111},
      1'b1, DEF_RES},
    '{'{SHAPE_SPHERE, DIM_MAX, 20'd0, 20'd0, 20'd0, 20'd0, 5'b10000},
      1'b1, '{DIM_MAX, 1'b0}},
    // sphere ignores span
    '{'{SHAPE_SPHERE, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 5'b01000},
      1'b1, DEF_RES},
    '{'{SHAPE_SPHERE, DIM_MAX, 20'd0, 20'd777, 20'd50, 20'd0, 5'b00110},
      1'b1, '{20'd777, 1'b0}},
    '{'{SHAPE_CONE, 20'd2000, 20'd0, 20'd3000, 20'd0, 20'd0, 5'b10100},
      1'b0, NO_RES},
    '{'{SHAPE_CONE, 20'd2000, 20'd0, 20'd800, 20'd600, 20'd300, 5'b00111},
      1'b0, NO_RES},
    '{'{SHAPE_CONE, 20'd2000, 20'd0, 20'd800, 20'd600, 20'd300, 5'b10011},
      1'b1, DEF_RES},
    '{'{SHAPE_SPHCYL_FIRST, 20'd4096, 20'd8192, 20'd1024, 20'd0, 20'd0, 5'b11100},
      1'b0, NO_RES},
    '{'{SHAPE_SPHCYL_LAST, 20'd4096, 20'd8192, 20'd1024, 20'd0, 20'd0, 5'b11000},
      1'b0, NO_RES},
    '{'{SHAPE_SPHCYL_LAST, 20'd4096, 20'd8192, 20'd1024, 20'd5, 20'd5, 5'b00111},
      1'b1, DEF_RES},
    '{'{SHAPE_SAIL_FIRST, 20'd0, DIM_MAX, 20'd1, 20'd0, 20'd0, 5'b01100},
      1'b0, NO_RES},
    '{'{SHAPE_SAIL_LAST, 20'd0, 20'd0, DIM_MAX, 20'd0, 20'd0, 5'b01100},
      1'b0, NO_RES},
    '{'{SHAPE_ANT_FIRST, 20'd0, DIM_MAX, 20'd0, DIM_MAX, DIM_MAX, 5'b01011},
      1'b0, NO_RES},
    '{'{SHAPE_ANT_LAST, 20'd0, 20'd500, 20'd0, 20'd500, 20'd500, 5'b01001},
      1'b1, DEF_RES}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_stall;
  logic [ShapeW-1:0] shape_class;
  logic [DIM_W-1:0] diameter_len;
  logic [DIM_W-1:0] span_len;
  logic [DIM_W-1:0] height_len;
  logic [DIM_W-1:0] width_len;
  logic [DIM_W-1:0] depth_len;
  logic             has_diameter;
  logic             has_span;
  logic             has_height;
  logic             has_width;
  logic             has_depth;
  logic             out_valid;
  logic             out_stall;
  logic [DIM_W-1:0] radius_len;
  logic             used_default;

  radius_res_t pending_radius_q[$];
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off_req;

  object_bounding_radius #(
    .DIM_WIDTH(DIM_W),
    .FRAC_BITS(FRAC_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .shape_class_i (shape_class),
    .diameter_len_i(diameter_len),
    .span_len_i    (span_len),
    .height_len_i  (height_len),
    .width_len_i   (width_len),
    .depth_len_i   (depth_len),
    .has_diameter_i(has_diameter),
    .has_span_i    (has_span),
    .has_height_i  (has_height),
    .has_width_i   (has_width),
    .has_depth_i   (has_depth),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .radius_len_o  (radius_len),
    .used_default_o(used_default)
  );

  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [31:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = {32'd0, root | (32'd1 << i)};
      if (trial * trial <= v) begin
        root = root | (32'd1 << i);
      end
    end
    return root;
  endfunction

  // floor(isqrt(a^2 + b^2) / 2), taken as isqrt of the quarter sum
  function automatic logic [DIM_W-1:0] half_diag(logic [DIM_W-1:0] a, logic [DIM_W-1:0] b);
    logic [63:0] wa;
    logic [63:0] wb;
    logic [31:0] root;
    wa = 64'(a);
    wb = 64'(b);
    root = floor_sqrt((wa * wa + wb * wb) >> 2);
    return DIM_W'(root);
  endfunction

  function automatic radius_res_t predict_radius(radius_req_t q);
    radius_res_t res;
    logic [DIM_W-1:0] wd;
    logic [DIM_W-1:0] big;
    logic d, s, h, w, p, ok;
    d = q.has[HAS_DIA];
    s = q.has[HAS_SPN];
    h = q.has[HAS_HGT];
    w = q.has[HAS_WID];
    p = q.has[HAS_DEP];
    wd = (q.wid > q.dep) ? q.wid : q.dep;
    ok = 1'b0;
    res.radius = '0;
    if (q.shape >= SHAPE_CYL_FIRST && q.shape <= SHAPE_CYL_LAST) begin
      if (d && h) begin res.radius = half_diag(q.dia, q.hgt); ok = 1'b1; end
    end else if ((q.shape >= SHAPE_PANEL_FIRST && q.shape <= SHAPE_PANEL_LAST) ||
                 (q.shape >= SHAPE_SAIL_FIRST && q.shape <= SHAPE_SAIL_LAST)) begin
      if (s && h) begin res.radius = half_diag(q.spn, q.hgt); ok = 1'b1; end
    end else if (q.shape == SHAPE_BOX) begin
      if (p && w && h) begin res.radius = half_diag(wd, q.hgt); ok = 1'b1; end
    end else if (q.shape == SHAPE_SPHERE) begin
      big = '0;
      if (d && q.dia > big) big = q.dia;
      if (w && q.wid > big) big = q.wid;
      if (p && q.dep > big) big = q.dep;
      if (h && q.hgt > big) big = q.hgt;
      if (big != '0) begin res.radius = big; ok = 1'b1; end
    end else if (q.shape == SHAPE_CONE) begin
      if (d && h) begin
        res.radius = half_diag(q.dia, q.hgt); ok = 1'b1;
      end else if (p && w && h) begin
        res.radius = half_diag(wd, q.hgt); ok = 1'b1;
      end
    end else if (q.shape >= SHAPE_SPHCYL_FIRST && q.shape <= SHAPE_SPHCYL_LAST) begin
      if (d && h) begin
        res.radius = half_diag(q.dia, q.hgt); ok = 1'b1;
      end else if (d && s) begin
        res.radius = half_diag(q.dia, q.spn); ok = 1'b1;
      end
    end else if (q.shape >= SHAPE_ANT_FIRST && q.shape <= SHAPE_ANT_LAST) begin
      if (p && w && s) begin res.radius = half_diag(wd, q.spn); ok = 1'b1; end
    end
    if (!ok) res.radius = ONE_METRE;
    res.used_default = !ok;
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] random_len();
    logic [DIM_W-1:0] len;
    case ($urandom_range(9))
      0: len = '0;
      1: len = DIM_MAX;
      2, 3: len = DIM_W'($urandom_range(63));
      default: len = DIM_W'($urandom);
    endcase
    return len;
  endfunction

  // mostly present lengths so that most objects reach a real radius
  function automatic radius_req_t random_req();
    radius_req_t q;
    q.shape = ShapeW'($urandom_range(31));
    q.dia = random_len();
    q.spn = random_len();
    q.hgt = random_len();
    q.wid = random_len();
    q.dep = random_len();
    for (int i = 0; i < 5; i++) begin
      q.has[i] = ($urandom_range(99) < 85);
    end
    return q;
  endfunction

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // entered and left at a falling edge
  task automatic send_req(radius_req_t q, logic known, radius_res_t given);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    shape_class = q.shape;
    diameter_len = q.dia;
    span_len = q.spn;
    height_len = q.hgt;
    width_len = q.wid;
    depth_len = q.dep;
    {has_diameter, has_span, has_height, has_width, has_depth} = q.has;
    do @(posedge clk_i); while (in_stall);
    pending_radius_q.insert(pending_radius_q.size(), known ? given : predict_radius(q));
    @(negedge clk_i);
  endtask

  task automatic send_random(int unsigned idle_pct, int unsigned stall_pct, int unsigned n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_req(random_req(), 1'b0, NO_RES);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver side stall, with an optional long hold-off counted here
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    radius_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_radius_q.size() == 0) begin
        note_fail($sformatf("unexpected result: radius %0d used_default %0b",
                            radius_len, used_default));
      end else begin
        want = pending_radius_q.pop_front();
        if (radius_len !== want.radius || used_default !== want.used_default) begin
          note_fail($sformatf("mismatch: radius %0d/%0d used_default %0b/%0b (exp/act)",
                              want.radius, radius_len, want.used_default, used_default));
        end
      end
    end
  end

  // ends the run when nothing moves on either channel for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    shape_class = '0;
    diameter_len = '0;
    span_len = '0;
    height_len = '0;
    width_len = '0;
    depth_len = '0;
    {has_diameter, has_span, has_height, has_width, has_depth} = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_req(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].res);
    end

    send_random(0, 0, 300);
    send_random(83, 0, 300);
    send_random(0, 83, 300);
    send_random(30, 30, 300);
    // long output hold-off while requests keep coming, fills the pipeline
    hold_off_req = 1'b1;
    send_random(0, 0, 250);

    in_valid = 1'b0;
    while (pending_radius_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
